// ===== rtl/core/cpfa_pkg.sv =====
// Shared types and constants for the colour pair find-or-allocate block.
package cpfa_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int COLOR_BITS    = 8;

    localparam int FIELD_W = 8;
    localparam int SLOT_W  = 8;
    localparam int KEY_W   = 2 * COLOR_BITS;
    localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
    localparam int NF_W    = ADDR_W + 1;

    localparam logic [NF_W-1:0] FIRST_SLOT = NF_W'(2);
    localparam logic [NF_W-1:0] FULL_MARK  = NF_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef enum logic {
        ACT_FIND  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [FIELD_W-1:0]   fore_color;
        logic [FIELD_W-1:0]   back_color;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

// ===== rtl/core/cpfa_engine.sv =====
// Search and allocate engine: pair memory, allocation counter and scan sequencer.
module cpfa_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cpfa_pkg::t_req       i_req,
    input  logic                 i_take,
    output cpfa_pkg::t_eng_stat  o_stat,
    output cpfa_pkg::t_rsp       o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [cpfa_pkg::NF_W-1:0]       r_next_free;
    logic [cpfa_pkg::NF_W-1:0]       r_rd_addr;
    logic [cpfa_pkg::ADDR_W-1:0]     r_cmp_addr;
    logic                            r_cmp_valid;
    logic [cpfa_pkg::KEY_W-1:0]      r_key;
    logic [cpfa_pkg::KEY_W-1:0]      r_rd_data;
    cpfa_pkg::t_rsp                  r_rsp;

    logic [cpfa_pkg::KEY_W-1:0]      r_mem [cpfa_pkg::TABLE_ENTRIES];

    logic                            w_hit;
    logic                            w_rd_en;
    logic                            w_miss;
    logic                            w_full;
    logic                            w_wr_en;
    logic [cpfa_pkg::KEY_W-1:0]      w_req_key;

    assign w_req_key = {cpfa_pkg::COLOR_BITS'(i_req.fore_color),
                        cpfa_pkg::COLOR_BITS'(i_req.back_color)};

    // The compare stage looks at the word read in the previous cycle while the
    // next address is already being read.
    assign w_hit   = (r_state == S_SCAN) && r_cmp_valid && (r_rd_data == r_key);
    assign w_rd_en = (r_state == S_SCAN) && !w_hit && (r_rd_addr < r_next_free);
    assign w_miss  = (r_state == S_SCAN) && !w_hit && !w_rd_en;
    assign w_full  = (r_next_free == cpfa_pkg::FULL_MARK);
    assign w_wr_en = w_miss && !w_full;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_next_free[cpfa_pkg::ADDR_W-1:0]] <= r_key;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_addr[cpfa_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= cpfa_pkg::FIRST_SLOT;
            r_cmp_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_req.action == cpfa_pkg::ACT_CLEAR) begin
                            r_next_free  <= cpfa_pkg::FIRST_SLOT;
                            r_rsp.slot   <= '0;
                            r_rsp.status <= cpfa_pkg::ST_CLEARED;
                            r_state      <= S_DONE;
                        end else begin
                            r_key       <= w_req_key;
                            r_rd_addr   <= cpfa_pkg::FIRST_SLOT;
                            r_cmp_valid <= 1'b0;
                            r_state     <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_rsp.slot   <= cpfa_pkg::SLOT_W'(r_cmp_addr);
                        r_rsp.status <= cpfa_pkg::ST_HIT;
                        r_cmp_valid  <= 1'b0;
                        r_state      <= S_DONE;
                    end else if (w_rd_en) begin
                        r_cmp_addr  <= r_rd_addr[cpfa_pkg::ADDR_W-1:0];
                        r_rd_addr   <= r_rd_addr + cpfa_pkg::NF_W'(1);
                        r_cmp_valid <= 1'b1;
                    end else begin
                        r_cmp_valid <= 1'b0;
                        r_state     <= S_DONE;
                        if (w_full) begin
                            r_rsp.slot   <= '0;
                            r_rsp.status <= cpfa_pkg::ST_FULL;
                        end else begin
                            r_rsp.slot   <= cpfa_pkg::SLOT_W'(r_next_free);
                            r_rsp.status <= cpfa_pkg::ST_ADDED;
                            r_next_free  <= r_next_free + cpfa_pkg::NF_W'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/color_pair_find_or_allocate_top.sv =====
// Top level of the colour pair find-or-allocate block.
//
// A request on the input channel (i_valid, o_stall, i_req) either looks up a
// foreground/background pair or clears the table. Each request yields one
// response on the output channel (o_valid, i_stall, o_rsp) giving the slot and
// a status: hit, newly added, table full or cleared.
// A request is taken when i_valid is high and o_stall is low. One request is
// worked on at a time; o_stall stays high from acceptance until its response
// has moved into the output register.
// A clear goes from acceptance straight to the finished state, then into the output
// register. A lookup reads the pair memory once per allocated slot, one read per
// cycle, stopping at the first match, then passes the finished state and the output
// register; at most 254 slots are allocated. The single read port of the pair memory
// sets this read rate.
// The output register holds a response while i_stall is high, and the engine
// keeps its finished response until the register can take it; a new request is
// accepted as soon as the engine has handed its response on.
// Reset empties the table (the allocation counter returns to slot 2) and
// drops any response held; the pair memory itself is not cleared.
module color_pair_find_or_allocate_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cpfa_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output cpfa_pkg::t_rsp  o_rsp
);

    cpfa_pkg::t_eng_stat w_eng_stat;
    cpfa_pkg::t_rsp      w_eng_rsp;
    logic                w_start;
    logic                w_take;
    logic                r_out_valid;
    cpfa_pkg::t_rsp      r_out_rsp;

    assign o_stall = !w_eng_stat.idle;
    assign w_start = i_valid && w_eng_stat.idle;
    assign w_take  = w_eng_stat.done && (!r_out_valid || !i_stall);

    cpfa_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_stat  (w_eng_stat),
        .o_rsp   (w_eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
            r_out_rsp   <= w_eng_rsp;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

endmodule

// ===== rtl/core/cpfa_checker.sv =====
// Port-level checker for the colour pair find-or-allocate block, with its bind.
module cpfa_port_checks (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  cpfa_pkg::t_req  i_req,
    input  logic            o_valid,
    input  logic            i_stall,
    input  cpfa_pkg::t_rsp  o_rsp
);

    // A held response must not change while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid straight after reset");

    // Only one request is in flight, so the block must stall after taking one.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted while one is in flight");

    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == cpfa_pkg::ST_FULL ||
                    o_rsp.status == cpfa_pkg::ST_CLEARED) |-> o_rsp.slot == '0)
        else $error("full or cleared response carries a non-zero slot");

endmodule

bind color_pair_find_or_allocate_top cpfa_port_checks u_cpfa_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ===== tb/cpfa_checker.sv =====
// Checker for the colour pair block: predicts each response and compares it on arrival.
`timescale 1ns / 100ps

module cpfa_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic            i_req_stall,
    input  cpfa_pkg::t_req  i_req,
    input  logic            i_rsp_valid,
    input  logic            i_rsp_stall,
    input  cpfa_pkg::t_rsp  i_rsp,
    output int              o_pending,
    output int              o_fail_count
);

    logic [cpfa_pkg::KEY_W-1:0] pair_mem [cpfa_pkg::TABLE_ENTRIES];
    logic [cpfa_pkg::NF_W-1:0]  alloc_ptr;
    cpfa_pkg::t_rsp             rsp_due_q [$];
    int                         mismatches = 0;

    // Searches the allocated slots for the pair and allocates one on a miss.
    function automatic cpfa_pkg::t_rsp find_or_allocate(input cpfa_pkg::t_req r);
        cpfa_pkg::t_rsp             rsp;
        logic [cpfa_pkg::KEY_W-1:0] key;
        bit                         found;
        rsp.slot   = '0;
        rsp.status = cpfa_pkg::ST_HIT;
        found      = 1'b0;
        if (r.action == cpfa_pkg::ACT_CLEAR) begin
            alloc_ptr  = cpfa_pkg::FIRST_SLOT;
            rsp.status = cpfa_pkg::ST_CLEARED;
        end else begin
            key = {r.fore_color[cpfa_pkg::COLOR_BITS-1:0],
                   r.back_color[cpfa_pkg::COLOR_BITS-1:0]};
            for (int s = int'(cpfa_pkg::FIRST_SLOT); s < int'(alloc_ptr); s++) begin
                if (!found && pair_mem[s] == key) begin
                    found    = 1'b1;
                    rsp.slot = cpfa_pkg::SLOT_W'(s);
                end
            end
            if (found) begin
                rsp.status = cpfa_pkg::ST_HIT;
            end else if (alloc_ptr < cpfa_pkg::FULL_MARK) begin
                rsp.slot   = cpfa_pkg::SLOT_W'(alloc_ptr);
                rsp.status = cpfa_pkg::ST_ADDED;
                pair_mem[alloc_ptr[cpfa_pkg::ADDR_W-1:0]] = key;
                alloc_ptr  = alloc_ptr + cpfa_pkg::NF_W'(1);
            end else begin
                rsp.slot   = '0;
                rsp.status = cpfa_pkg::ST_FULL;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        cpfa_pkg::t_rsp want;
        if (!i_rst_n) begin
            alloc_ptr = cpfa_pkg::FIRST_SLOT;
            rsp_due_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                rsp_due_q.push_back(find_or_allocate(i_req));
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_due_q.size() == 0) begin
                    $error("unexpected response: slot %0d, status %0d",
                           i_rsp.slot, i_rsp.status);
                    mismatches++;
                end else begin
                    want = rsp_due_q.pop_front();
                    if (i_rsp.slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, i_rsp.slot);
                        mismatches++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_rsp.status);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= rsp_due_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/color_pair_find_or_allocate_top_test.sv =====
// Testbench top for the colour pair block: drives requests and gives the verdict.
`timescale 1ns / 100ps

module color_pair_find_or_allocate_top_test;

    localparam int TOTAL_REQS = 1650;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           req_valid;
    logic           req_stall;
    cpfa_pkg::t_req req;
    logic           rsp_valid;
    logic           rsp_stall;
    cpfa_pkg::t_rsp rsp;
    int             pending;
    int             fail_count;
    int             reqs_sent  = 0;
    int             rsps_taken = 0;
    bit             sender_calm;
    bit             receiver_calm;

    always #6 i_clk = ~i_clk;

    color_pair_find_or_allocate_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_req   (req),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_rsp   (rsp)
    );

    cpfa_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Offers one request after a random gap and returns once it is taken.
    task automatic send_request(input cpfa_pkg::t_action act, input int fore,
                                input int back);
        int gap;
        if (reqs_sent % 40 == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
        end
        gap = sender_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid       <= 1'b1;
        req.action      <= act;
        req.fore_color  <= cpfa_pkg::FIELD_W'(fore);
        req.back_color  <= cpfa_pkg::FIELD_W'(back);
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        reqs_sent++;
    endtask

    // Response side: random hold-offs, calm stretches and two long holds
    // that back the block up into its request channel.
    initial begin : receiver
        int hold;
        rsp_stall <= 1'b0;
        forever begin
            if (rsps_taken % 40 == 0) begin
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            hold = receiver_calm ? 0 : $urandom_range(0, 10);
            if (rsps_taken == 150 || rsps_taken == 900) begin
                hold = 400;
            end
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            rsp_stall <= 1'b0;
            @(posedge i_clk);
            while (!rsp_valid) @(posedge i_clk);
            rsps_taken++;
        end
    end

    initial begin : stimulus
        cpfa_pkg::t_req known_q [$];
        cpfa_pkg::t_req pick;
        int             seg_len;
        int             new_pct;
        int             first_seg;
        i_rst_n   <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Colour extremes, hits, misses, and clears on a non-empty and an empty table.
        send_request(cpfa_pkg::ACT_FIND, 0, 0);
        send_request(cpfa_pkg::ACT_FIND, 0, 0);
        send_request(cpfa_pkg::ACT_FIND, 255, 255);
        send_request(cpfa_pkg::ACT_FIND, 255, 0);
        send_request(cpfa_pkg::ACT_FIND, 0, 255);
        send_request(cpfa_pkg::ACT_FIND, 8'hAA, 8'h55);
        send_request(cpfa_pkg::ACT_FIND, 8'h55, 8'hAA);
        send_request(cpfa_pkg::ACT_FIND, 255, 255);
        send_request(cpfa_pkg::ACT_FIND, 0, 255);
        send_request(cpfa_pkg::ACT_CLEAR, 255, 255);
        send_request(cpfa_pkg::ACT_FIND, 255, 255);
        send_request(cpfa_pkg::ACT_FIND, 0, 0);
        send_request(cpfa_pkg::ACT_CLEAR, 0, 0);
        send_request(cpfa_pkg::ACT_CLEAR, 8'h5A, 8'hA5);
        send_request(cpfa_pkg::ACT_FIND, 1, 2);
        send_request(cpfa_pkg::ACT_FIND, 2, 1);
        send_request(cpfa_pkg::ACT_FIND, 1, 2);
        send_request(cpfa_pkg::ACT_FIND, 128, 1);
        send_request(cpfa_pkg::ACT_FIND, 1, 128);
        send_request(cpfa_pkg::ACT_FIND, 2, 1);
        send_request(cpfa_pkg::ACT_CLEAR, 0, 255);

        // Random segments, each ending in a clear. The first one is long enough
        // to fill the table, so lookups on a full table get exercised.
        first_seg = 1;
        while (reqs_sent < TOTAL_REQS) begin
            if (first_seg != 0) begin
                seg_len   = 600;
                new_pct   = 75;
                first_seg = 0;
            end else begin
                seg_len = $urandom_range(5, 400);
                new_pct = $urandom_range(10, 90);
            end
            for (int n = 0; n < seg_len && reqs_sent < TOTAL_REQS; n++) begin
                if ($urandom_range(0, 199) == 0) begin
                    send_request(cpfa_pkg::ACT_CLEAR, $urandom_range(0, 255),
                                 $urandom_range(0, 255));
                end else begin
                    if (known_q.size() == 0 || $urandom_range(0, 99) < new_pct) begin
                        pick.action     = cpfa_pkg::ACT_FIND;
                        pick.fore_color = cpfa_pkg::FIELD_W'($urandom());
                        pick.back_color = cpfa_pkg::FIELD_W'($urandom());
                        known_q.push_back(pick);
                    end else begin
                        pick = known_q[$urandom_range(0, known_q.size() - 1)];
                    end
                    send_request(cpfa_pkg::ACT_FIND, pick.fore_color, pick.back_color);
                end
            end
            send_request(cpfa_pkg::ACT_CLEAR, $urandom_range(0, 255),
                         $urandom_range(0, 255));
            known_q.delete();
        end
        req_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // Time for any stray response to show up after the last expected one.
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("color_pair_find_or_allocate_top test passed");
        end else begin
            $display("color_pair_find_or_allocate_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("color_pair_find_or_allocate_top test failed");
        $finish;
    end

endmodule
